// File: hw/rtl/rsdm_pkg.sv
// ----------------------------------------------------------------------------
// rsdm_pkg - shared types and helpers for the record sorter
// Record key layout, cell control bundle and the distinguishing-mask function.
// ----------------------------------------------------------------------------
`default_nettype none

package rsdm_pkg;

   localparam int MAX_RECORDS = 16;
   localparam int IDX_W       = 6;
   localparam int MASK_W      = 5;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 64;

   // Field positions within want_mask and within the key walk
   localparam logic [2:0] FLD_MACHINE    = 3'd0;
   localparam logic [2:0] FLD_WORD_WIDTH = 3'd1;
   localparam logic [2:0] FLD_BYTE_ORD   = 3'd2;
   localparam logic [2:0] FLD_ABI_ID     = 3'd3;
   localparam logic [2:0] FLD_ABI_VER    = 3'd4;

   // Most significant field first, so the packed value compares as the composite key
   typedef struct packed {
      logic [15:0] machine_code;
      logic [7:0]  word_width;
      logic [7:0]  endian;
      logic [7:0]  abi_id;
      logic [7:0]  abi_version;
   } key_type;

   typedef struct packed {
      key_type          key;
      logic [IDX_W-1:0] record_index;
   } entry_type;

   typedef struct packed {
      logic    insert;
      logic    shift;
      key_type new_key;
      logic [IDX_W-1:0] new_index;
   } cell_ctl_type;

   // Index of the first key field in which two records differ; equal keys
   // never drop out, which is the same as stopping at the last field.
   function automatic logic [2:0] first_diff(input key_type a, input key_type b);
      logic [2:0] f;
      f = FLD_ABI_VER;
      if (a.machine_code != b.machine_code) begin
         f = FLD_MACHINE;
      end else if (a.word_width != b.word_width) begin
         f = FLD_WORD_WIDTH;
      end else if (a.endian != b.endian) begin
         f = FLD_BYTE_ORD;
      end else if (a.abi_id != b.abi_id) begin
         f = FLD_ABI_ID;
      end
      return f;
   endfunction

   function automatic logic [MASK_W-1:0] want_mask_fn(
      input key_type cur,
      input key_type prv,
      input logic    has_prev,
      input key_type nxt,
      input logic    has_next
   );
      logic [2:0] dp;
      logic [2:0] dn;
      logic [2:0] stop;
      logic [MASK_W-1:0] m;
      dp   = has_prev ? first_diff(cur, prv) : FLD_MACHINE;
      dn   = has_next ? first_diff(cur, nxt) : FLD_MACHINE;
      stop = (dp > dn) ? dp : dn;
      case (stop)
         FLD_MACHINE:    m = 5'b00001;
         FLD_WORD_WIDTH: m = 5'b00011;
         FLD_BYTE_ORD:   m = 5'b00111;
         FLD_ABI_ID:     m = 5'b01111;
         default:        m = 5'b11111;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/record_sort_distinguishing_mask.sv
// ----------------------------------------------------------------------------
// record_sort_distinguishing_mask - stable composite-key record sorter
// Loads a set of records into an insertion chain, then emits them in
// ascending key order with their load index and distinguishing mask.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one record per item; req_tlast closes the set. Records are
//   inserted into their sorted place as they arrive, one item per cycle
//   while req_tready is high. A record arriving while MaxRecords are held is
//   dropped; a dropped record carrying req_tlast still closes the set.
//   After the closing item the chain pops one record per cycle onto rsp_*
//   while the output register is empty or rsp_tready is high. rsp_tlast
//   marks the last item of the set. The chain has a single pop port, so
//   req_tready is low from the cycle after the closing item until the last
//   record has moved into the output register; the next set then loads
//   while it waits.
//   A stall on rsp_tready holds the output register and the chain.
//   Reset empties the chain, clears the record count and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

module record_sort_distinguishing_mask #(
   parameter int MaxRecords = rsdm_pkg::MAX_RECORDS
) (
   input  wire                              clock,
   input  wire                              reset,
   // tdata: machine_code[15:0], word_width[23:16], endian[31:24],
   //        abi_id[39:32], abi_version[47:40]
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [rsdm_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire                              req_tlast,
   // tdata: record_index[5:0], out_machine[21:6], out_word_width[29:22],
   //        out_endian[37:30], out_abi_id[45:38], out_abi_version[53:46],
   //        want_mask[58:54], zero[63:59]
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [rsdm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int CntW = $clog2(MaxRecords + 1);
   localparam int IdxW = rsdm_pkg::IDX_W;

   logic                   count_full;
   logic [CntW-1:0]        count_ff;
   logic [CntW-1:0]        count_in;
   logic                   req_take;
   logic                   busy;
   logic                   pop;
   rsdm_pkg::cell_ctl_type ctl;
   rsdm_pkg::key_type      req_key;
   rsdm_pkg::entry_type    idle_entry;

   logic                   cell_gt    [MaxRecords];
   logic                   cell_valid [MaxRecords];
   rsdm_pkg::entry_type    cell_entry [MaxRecords];

   assign req_tready = !busy;
   assign req_take   = req_tvalid && req_tready;
   assign count_full = (count_ff == CntW'(MaxRecords));

   assign req_key.machine_code = req_tdata[15:0];
   assign req_key.word_width   = req_tdata[23:16];
   assign req_key.endian       = req_tdata[31:24];
   assign req_key.abi_id       = req_tdata[39:32];
   assign req_key.abi_version  = req_tdata[47:40];

   assign idle_entry = '0;

   assign ctl.insert    = req_take && !count_full;
   assign ctl.shift     = pop;
   assign ctl.new_key   = req_key;
   assign ctl.new_index = IdxW'(count_ff);

   always_comb begin
      count_in = count_ff;
      if (req_take && req_tlast) begin
         count_in = '0;
      end else if (ctl.insert) begin
         count_in = count_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < MaxRecords; i++) begin : g_cell
      logic                lgt;
      logic                lvalid;
      rsdm_pkg::entry_type lentry;
      logic                rvalid;
      rsdm_pkg::entry_type rentry;

      if (i == 0) begin : g_head
         assign lgt    = 1'b0;
         assign lvalid = 1'b0;
         assign lentry = idle_entry;
      end else begin : g_body
         assign lgt    = cell_gt[i-1];
         assign lvalid = cell_valid[i-1];
         assign lentry = cell_entry[i-1];
      end

      if (i == MaxRecords - 1) begin : g_tail
         assign rvalid = 1'b0;
         assign rentry = idle_entry;
      end else begin : g_inner
         assign rvalid = cell_valid[i+1];
         assign rentry = cell_entry[i+1];
      end

      rsdm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_gt     (lgt),
         .left_valid  (lvalid),
         .left_entry  (lentry),
         .right_valid (rvalid),
         .right_entry (rentry),
         .gt          (cell_gt[i]),
         .valid       (cell_valid[i]),
         .entry       (cell_entry[i])
      );
   end

   rsdm_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (req_take && req_tlast),
      .head_entry (cell_entry[0]),
      .next_valid (cell_valid[1]),
      .next_entry (cell_entry[1]),
      .busy       (busy),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   logic [MaxRecords-1:0] valid_vec;
   for (genvar i = 0; i < MaxRecords; i++) begin : g_vec
      assign valid_vec[i] = cell_valid[i];
   end

   a_head_held_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> cell_valid[0])
      else $error("emission active with an empty chain head");

   a_count_tracks_chain: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (CntW'($countones(valid_vec)) == count_ff))
      else $error("record count disagrees with occupied cells");

   for (genvar i = 0; i < MaxRecords - 1; i++) begin : g_chk
      a_chain_sorted: assert property (@(posedge clock) disable iff (reset)
         cell_valid[i+1] |-> (cell_valid[i] &&
                              (cell_entry[i].key <= cell_entry[i+1].key)))
         else $error("insertion chain out of order or has a gap");
   end

endmodule

`default_nettype wire

// File: hw/rtl/rsdm_cell.sv
// ----------------------------------------------------------------------------
// rsdm_cell - one slot of the insertion chain
// Holds one record; on insert it keeps, takes the new record or takes its left
// neighbor's, and on shift it takes its right neighbor's record.
// ----------------------------------------------------------------------------
`default_nettype none

module rsdm_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  rsdm_pkg::cell_ctl_type   ctl,
   input  wire                      left_gt,
   input  wire                      left_valid,
   input  rsdm_pkg::entry_type      left_entry,
   input  wire                      right_valid,
   input  rsdm_pkg::entry_type      right_entry,
   output logic                     gt,
   output logic                     valid,
   output rsdm_pkg::entry_type      entry
);

   logic                valid_ff;
   logic                valid_in;
   rsdm_pkg::entry_type entry_ff;
   rsdm_pkg::entry_type entry_in;

   // Strictly greater: a new record goes after equal keys, which keeps load order
   assign gt = !valid_ff || (entry_ff.key > ctl.new_key);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (left_gt) begin
            valid_in = left_valid;
            entry_in = left_entry;
         end else if (gt) begin
            valid_in = 1'b1;
            entry_in.key          = ctl.new_key;
            entry_in.record_index = ctl.new_index;
         end
      end else if (ctl.shift) begin
         valid_in = right_valid;
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rsdm_emit.sv
// ----------------------------------------------------------------------------
// rsdm_emit - output stage of the sorter
// Pops the head of the chain one item at a time, builds the distinguishing
// mask from the previous and next records, and holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rsdm_emit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  rsdm_pkg::entry_type                 head_entry,
   input  wire                                 next_valid,
   input  rsdm_pkg::entry_type                 next_entry,
   output logic                                busy,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [rsdm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);

   logic                busy_ff;
   logic                busy_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic                has_prev_ff;
   logic                has_prev_in;
   rsdm_pkg::entry_type prev_ff;
   rsdm_pkg::entry_type out_entry_ff;
   logic [rsdm_pkg::MASK_W-1:0] out_mask_ff;
   logic                out_last_ff;
   logic [rsdm_pkg::MASK_W-1:0] mask;

   assign pop  = busy_ff && (!out_valid_ff || rsp_tready);
   assign mask = rsdm_pkg::want_mask_fn(head_entry.key, prev_ff.key, has_prev_ff,
                                        next_entry.key, next_valid);

   always_comb begin
      busy_in      = busy_ff;
      has_prev_in  = has_prev_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (start) begin
         busy_in     = 1'b1;
         has_prev_in = 1'b0;
      end else if (pop) begin
         out_valid_in = 1'b1;
         has_prev_in  = 1'b1;
         // Drop out of emission once the tail has left the chain
         if (!next_valid) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         has_prev_ff  <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         has_prev_ff  <= has_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         prev_ff      <= head_entry;
         out_entry_ff <= head_entry;
         out_mask_ff  <= mask;
         out_last_ff  <= !next_valid;
      end
   end

   assign busy       = busy_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {5'd0,
                        out_mask_ff,
                        out_entry_ff.key.abi_version,
                        out_entry_ff.key.abi_id,
                        out_entry_ff.key.endian,
                        out_entry_ff.key.word_width,
                        out_entry_ff.key.machine_code,
                        out_entry_ff.record_index};

endmodule

`default_nettype wire

// File: tb/sv/tb_record_sort_distinguishing_mask.sv
// ----------------------------------------------------------------------------
// tb_record_sort_distinguishing_mask - record sorter testbench
// Drives sets of records into the sorter and checks every emitted record
// against a local stable sort and mask walk. Both stream sides idle at
// random in several phases; the result side also holds off for a long
// stretch so that the chain fills up and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_record_sort_distinguishing_mask;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES = 120;

   typedef struct {
      logic [rsdm_pkg::IDX_W-1:0]  record_index;
      rsdm_pkg::key_type           key;
      logic [rsdm_pkg::MASK_W-1:0] want_mask;
      logic                        last_out;
   } sorted_record_type;

   class sort_scoreboard;
      rsdm_pkg::key_type          held_key [rsdm_pkg::MAX_RECORDS];
      logic [rsdm_pkg::IDX_W-1:0] held_idx [rsdm_pkg::MAX_RECORDS];
      int unsigned                held_count;
      sorted_record_type          emit_q [$];
      int unsigned                errors;

      function new();
         held_count = 0;
         errors = 0;
      endfunction

      static function logic [15:0] key_field(rsdm_pkg::key_type k, int f);
         case (f)
            rsdm_pkg::FLD_MACHINE:    return k.machine_code;
            rsdm_pkg::FLD_WORD_WIDTH: return {8'h00, k.word_width};
            rsdm_pkg::FLD_BYTE_ORD:   return {8'h00, k.endian};
            rsdm_pkg::FLD_ABI_ID:     return {8'h00, k.abi_id};
            default:                  return {8'h00, k.abi_version};
         endcase
      endfunction

      // Store the record, and on the closing item sort and queue the set
      function void note_record(rsdm_pkg::key_type k, logic closes);
         rsdm_pkg::key_type          sk [rsdm_pkg::MAX_RECORDS];
         logic [rsdm_pkg::IDX_W-1:0] si [rsdm_pkg::MAX_RECORDS];
         rsdm_pkg::key_type          vk;
         logic [rsdm_pkg::IDX_W-1:0] vi;
         int                         j;
         logic                       alive_prev;
         logic                       alive_next;
         sorted_record_type          r;
         if (held_count < rsdm_pkg::MAX_RECORDS) begin
            held_key[held_count] = k;
            held_idx[held_count] = rsdm_pkg::IDX_W'(held_count);
            held_count++;
         end
         if (!closes) return;
         for (int i = 0; i < held_count; i++) begin
            sk[i] = held_key[i];
            si[i] = held_idx[i];
         end
         // insertion sort on key, then load index, keeps equal keys in order
         for (int i = 1; i < held_count; i++) begin
            vk = sk[i];
            vi = si[i];
            j = i;
            while (j > 0 && {sk[j-1], si[j-1]} > {vk, vi}) begin
               sk[j] = sk[j-1];
               si[j] = si[j-1];
               j--;
            end
            sk[j] = vk;
            si[j] = vi;
         end
         for (int i = 0; i < held_count; i++) begin
            alive_prev = (i > 0);
            alive_next = (i + 1 < held_count);
            r.want_mask = '0;
            for (int f = 0; f < 5; f++) begin
               r.want_mask[f] = 1'b1;
               if (alive_prev && key_field(sk[i-1], f) != key_field(sk[i], f))
                  alive_prev = 1'b0;
               if (alive_next && key_field(sk[i+1], f) != key_field(sk[i], f))
                  alive_next = 1'b0;
               if (!alive_prev && !alive_next) break;
            end
            r.record_index = si[i];
            r.key = sk[i];
            r.last_out = (i + 1 == held_count);
            emit_q.push_back(r);
         end
         held_count = 0;
      endfunction

      function void check_result(logic [rsdm_pkg::RSP_DATA_W-1:0] data, logic last);
         sorted_record_type e;
         if (emit_q.size() == 0) begin
            $error("result item with no record expected: data %0h last %0b", data, last);
            errors++;
            return;
         end
         e = emit_q.pop_front();
         if (data[5:0] !== e.record_index) begin
            $error("record_index: expected %0d, got %0d", e.record_index, data[5:0]);
            errors++;
         end
         if (data[21:6] !== e.key.machine_code) begin
            $error("out_machine: expected %0h, got %0h", e.key.machine_code, data[21:6]);
            errors++;
         end
         if (data[29:22] !== e.key.word_width) begin
            $error("out_word_width: expected %0h, got %0h", e.key.word_width, data[29:22]);
            errors++;
         end
         if (data[37:30] !== e.key.endian) begin
            $error("out_endian: expected %0h, got %0h", e.key.endian, data[37:30]);
            errors++;
         end
         if (data[45:38] !== e.key.abi_id) begin
            $error("out_abi_id: expected %0h, got %0h", e.key.abi_id, data[45:38]);
            errors++;
         end
         if (data[53:46] !== e.key.abi_version) begin
            $error("out_abi_version: expected %0h, got %0h",
                   e.key.abi_version, data[53:46]);
            errors++;
         end
         if (data[58:54] !== e.want_mask) begin
            $error("want_mask: expected %0h, got %0h", e.want_mask, data[58:54]);
            errors++;
         end
         if (data[63:59] !== 5'b0) begin
            $error("tdata padding: expected 0, got %0h", data[63:59]);
            errors++;
         end
         if (last !== e.last_out) begin
            $error("last_out: expected %0b, got %0b", e.last_out, last);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return emit_q.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   wire                             req_tready;
   logic [rsdm_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tlast = 1'b0;
   wire                             rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   wire [rsdm_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   wire                             rsp_tlast;

   sort_scoreboard sb = new();
   int unsigned    cycle_count = 0;
   int unsigned    records_sent = 0;
   int unsigned    sender_idle_pct = 0;
   int unsigned    receiver_idle_pct = 0;
   int unsigned    hold_asks = 0;
   int unsigned    hold_seen = 0;
   int unsigned    hold_left = 0;

   record_sort_distinguishing_mask DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: a long hold-off when asked, random stalls otherwise
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_record(rsdm_pkg::key_type'({req_tdata[15:0], req_tdata[23:16],
                                             req_tdata[31:24], req_tdata[39:32],
                                             req_tdata[47:40]}), req_tlast);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tlast);
   end

   function automatic rsdm_pkg::key_type make_key(logic [15:0] m, logic [7:0] w,
                                                  logic [7:0] b, logic [7:0] a,
                                                  logic [7:0] v);
      return rsdm_pkg::key_type'({m, w, b, a, v});
   endfunction

   function automatic logic [15:0] draw_pool_value();
      case ($urandom_range(0, 4))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_record(input rsdm_pkg::key_type k, input logic closes);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {k.abi_version, k.abi_id, k.endian, k.word_width, k.machine_code};
      req_tlast  <= closes;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      records_sent++;
   endtask

   // Draw each field mostly from a two-value pool so that keys tie at every level
   task automatic send_random_set(input int unsigned n);
      logic [15:0]       mach_pool [2];
      logic [7:0]        byte_pool [4][2];
      logic [15:0]       tmp;
      rsdm_pkg::key_type k;
      for (int p = 0; p < 2; p++) begin
         mach_pool[p] = draw_pool_value();
         for (int f = 0; f < 4; f++) begin
            tmp = draw_pool_value();
            byte_pool[f][p] = tmp[7:0];
         end
      end
      for (int i = 0; i < n; i++) begin
         k = rsdm_pkg::key_type'($urandom_range(0, 5) == 0 ? {$urandom, $urandom} : '0);
         if ($urandom_range(0, 5) != 0) k.machine_code = mach_pool[$urandom_range(0, 1)];
         if ($urandom_range(0, 5) != 0) k.word_width   = byte_pool[0][$urandom_range(0, 1)];
         if ($urandom_range(0, 5) != 0) k.endian       = byte_pool[1][$urandom_range(0, 1)];
         if ($urandom_range(0, 5) != 0) k.abi_id       = byte_pool[2][$urandom_range(0, 1)];
         if ($urandom_range(0, 5) != 0) k.abi_version  = byte_pool[3][$urandom_range(0, 1)];
         send_record(k, i == n - 1);
      end
   endtask

   initial begin
      int unsigned set_size;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single record: machine field alone tells it apart
      send_record(make_key(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1);
      // one record per level of difference, extremes included, loaded out of order
      send_record(make_key(16'h1234, 8'h56, 8'h78, 8'h9A, 8'hFF), 1'b0);
      send_record(make_key(16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
      send_record(make_key(16'h1234, 8'h56, 8'h78, 8'h9A, 8'hBC), 1'b0);
      send_record(make_key(16'h1234, 8'h56, 8'h78, 8'h00, 8'hBC), 1'b0);
      send_record(make_key(16'h1234, 8'h00, 8'h78, 8'h9A, 8'hBC), 1'b0);
      send_record(make_key(16'h1234, 8'h56, 8'hFF, 8'h9A, 8'hBC), 1'b0);
      send_record(make_key(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
      // identical keys: load order kept, middle record needs every field
      send_record(make_key(16'h00A5, 8'h5A, 8'hA5, 8'h5A, 8'hA5), 1'b0);
      send_record(make_key(16'h00A5, 8'h5A, 8'hA5, 8'h5A, 8'hA5), 1'b0);
      send_record(make_key(16'h00A5, 8'h5A, 8'hA5, 8'h5A, 8'hA5), 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct   = (phase == 1) ? 46 : (phase == 3) ? 26 : 0;
         receiver_idle_pct = (phase == 2) ? 46 : (phase == 3) ? 26 : 0;
         if (phase == 0) begin
            // hold the result side while an overfull set and the next one arrive
            hold_asks++;
            send_random_set(rsdm_pkg::MAX_RECORDS + 1);
            send_random_set(6);
         end
         while (records_sent < 11 + 50 * (phase + 1)) begin
            case ($urandom_range(0, 11))
               0:       set_size = $urandom_range(rsdm_pkg::MAX_RECORDS,
                                                  rsdm_pkg::MAX_RECORDS + 4);
               1:       set_size = 1;
               default: set_size = $urandom_range(2, 8);
            endcase
            send_random_set(set_size);
         end
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/rsdm_pkg.sv
hw/rtl/rsdm_cell.sv
hw/rtl/rsdm_emit.sv
hw/rtl/record_sort_distinguishing_mask.sv
tb/sv/tb_record_sort_distinguishing_mask.sv
